// File: rtl/drive_state_transition_sequencer_unit_assert.svh
// Assertion helpers used by the sequencer RTL.
`ifndef DRIVE_STATE_TRANSITION_SEQUENCER_UNIT_ASSERT_SVH
`define DRIVE_STATE_TRANSITION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define DSTS_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("dsts assertion failed");

// Next-cycle implication, ignored while reset is high.
`define DSTS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("dsts assertion failed");

`endif

// File: rtl/dsts_pkg.sv
package dsts_pkg;

   // poll counter
   localparam int COUNT_WIDTH = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CMP_WIDTH-1:0]   cmp_type;
   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // status word masks and patterns
   localparam logic [15:0] MASK_A      = 16'h004F;
   localparam logic [15:0] MASK_B      = 16'h006F;
   localparam logic [15:0] PAT_SOD     = 16'h0040;
   localparam logic [15:0] PAT_FREACT  = 16'h000F;
   localparam logic [15:0] PAT_FAULT   = 16'h0008;
   localparam logic [15:0] PAT_NOTRDY  = 16'h0000;
   localparam logic [15:0] PAT_READY   = 16'h0021;
   localparam logic [15:0] PAT_SWON    = 16'h0023;
   localparam logic [15:0] PAT_ENABLED = 16'h0027;
   localparam logic [15:0] PAT_QSTOP   = 16'h0007;

   // control words
   localparam logic [15:0] CW_SHUTDOWN        = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON       = 16'h0007;
   localparam logic [15:0] CW_ENABLE_OP       = 16'h000F;
   localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;

   typedef enum logic [3:0] {
      ST_NOT_READY      = 4'd0,
      ST_SW_ON_DISABLED = 4'd1,
      ST_READY          = 4'd2,
      ST_SWITCHED_ON    = 4'd3,
      ST_ENABLED        = 4'd4,
      ST_QUICK_STOP     = 4'd5,
      ST_FAULT_REACTION = 4'd6,
      ST_FAULT          = 4'd7,
      ST_UNKNOWN        = 4'd8
   } state_type;

   typedef enum logic [2:0] {
      OUT_BUSY        = 3'd0,
      OUT_REACHED     = 3'd1,
      OUT_FAULT       = 3'd2,
      OUT_UNSUPPORTED = 3'd3,
      OUT_TIMEOUT     = 3'd4,
      OUT_ERROR       = 3'd5
   } outcome_type;

   // register map
   localparam logic REG_TARGET    = 1'b0;
   localparam logic REG_MAX_POLLS = 1'b1;
   localparam logic [3:0]  TARGET_RESET    = 4'd4;
   localparam logic [15:0] MAX_POLLS_RESET = 16'd100;

   typedef struct packed {
      logic [3:0]  target_state;
      logic [15:0] max_polls;
   } cfg_type;

   // classified poll handed from front to back
   typedef struct packed {
      logic      err;
      state_type state;
   } entry_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   typedef logic [QPTR_WIDTH-1:0] qptr_type;
   typedef logic [$clog2(QUEUE_DEPTH+1)-1:0] qcount_type;

   // result word, lowest field last in this list
   typedef struct packed {
      outcome_type outcome;
      logic [15:0] command_out;
      logic        command_valid;
      state_type   decoded_state;
   } rsp_word_type;

endpackage

// File: rtl/drive_state_transition_sequencer_unit.sv
// An accepted word is written into the queue, then popped into the rsp result register.
// Throughput: one word per cycle while rsp_tready keeps the result register draining.
// The front stalls only when the two-entry queue is full; the back only on rsp_tready.
// Reset (synchronous, active high): empties the queue, drops rsp_tvalid, clears the
// poll counter, and loads target_state = 4 and max_polls = 100.
`include "drive_state_transition_sequencer_unit_assert.svh"

module drive_state_transition_sequencer_unit import dsts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // poll input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] status_reading
   input  logic [0:0]  req_tuser,   // [0] read_failed
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] decoded_state, [4] command_valid,
                                    // [20:5] command_out, [23:21] outcome
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers. Register index is paddr[2]; the two low
   // address bits are don't-care.
   // ---------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;
   logic    csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_TARGET:    cfg_in.target_state = csr_pwdata[3:0];
            REG_MAX_POLLS: cfg_in.max_polls    = csr_pwdata[15:0];
            default:       cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_state <= TARGET_RESET;
         cfg_ff.max_polls    <= MAX_POLLS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TARGET:    csr_prdata = {28'd0, cfg_ff.target_state};
         REG_MAX_POLLS: csr_prdata = {16'd0, cfg_ff.max_polls};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Front: classify the status word and push it into the queue.
   // ---------------------------------------------------------------
   entry_type    front_entry;
   entry_type    queue_head;
   logic         queue_full;
   logic         queue_not_empty;
   logic         queue_pop;
   logic         req_accept;
   rsp_word_type rsp_word;

   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   dsts_front u_front (
      .status_reading (req_tdata),
      .read_failed    (req_tuser[0]),
      .cfg            (cfg_ff),
      .entry          (front_entry)
   );

   // two entries: keeps full rate with a registered ready
   dsts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .head       (queue_head)
   );

   // ---------------------------------------------------------------
   // Back: target compare, command pick, poll counter, result reg.
   // ---------------------------------------------------------------
   dsts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry_valid (queue_not_empty),
      .entry       (queue_head),
      .entry_pop   (queue_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_word    (rsp_word)
   );

   assign rsp_tdata = rsp_word;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   logic cmd_seen, cmd_legal;
   logic err_seen, err_clean;

   assign cmd_seen  = rsp_tvalid && rsp_word.command_valid;
   assign cmd_legal = (rsp_word.outcome == OUT_BUSY) || (rsp_word.outcome == OUT_TIMEOUT);
   assign err_seen  = rsp_tvalid && (rsp_word.outcome == OUT_ERROR);
   assign err_clean = (rsp_word.decoded_state == ST_UNKNOWN) && !rsp_word.command_valid;

   // a command goes out only while sequencing or on the timeout poll
   `DSTS_ASSERT_NOW(a_cmd_outcome, clock, reset, cmd_seen, cmd_legal)
   // error results carry no state and no command
   `DSTS_ASSERT_NOW(a_err_clean, clock, reset, err_seen, err_clean)
   // a popped entry always lands in the result register
   `DSTS_ASSERT_NEXT(a_pop_lands, clock, reset, queue_pop, rsp_tvalid)

endmodule

// File: rtl/dsts_front.sv
module dsts_front import dsts_pkg::*; (
   input  logic [15:0] status_reading,
   input  logic        read_failed,
   input  cfg_type     cfg,
   output entry_type   entry
);

   function automatic state_type classify(input logic [15:0] w);
      state_type st;
      st = ST_UNKNOWN;
      unique case (w & MASK_A)
         PAT_NOTRDY: st = ST_NOT_READY;
         PAT_SOD:    st = ST_SW_ON_DISABLED;
         PAT_FREACT: st = ST_FAULT_REACTION;
         PAT_FAULT:  st = ST_FAULT;
         default: begin
            unique case (w & MASK_B)
               PAT_READY:   st = ST_READY;
               PAT_SWON:    st = ST_SWITCHED_ON;
               PAT_ENABLED: st = ST_ENABLED;
               PAT_QSTOP:   st = ST_QUICK_STOP;
               default:     st = ST_UNKNOWN;
            endcase
         end
      endcase
      return st;
   endfunction

   // failed read or zero limit: word not looked at
   always_comb begin
      entry.err   = read_failed || (cfg.max_polls == 16'd0);
      entry.state = entry.err ? ST_UNKNOWN : classify(status_reading);
   end

endmodule

// File: rtl/dsts_queue.sv
module dsts_queue import dsts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   entry_type  slot_ff [QUEUE_DEPTH];
   qptr_type   wr_ptr_ff, wr_ptr_in;
   qptr_type   rd_ptr_ff, rd_ptr_in;
   qcount_type count_ff, count_in;

   function automatic qptr_type ptr_inc(input qptr_type p);
      return (p == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : qptr_type'(p + 1'b1);
   endfunction

   assign full      = (count_ff == qcount_type'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = qcount_type'(count_ff + 1'b1);
      if (pop && !push) count_in = qcount_type'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: rtl/dsts_back.sv
module dsts_back import dsts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         entry_valid,
   input  entry_type    entry,
   output logic         entry_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff,  rsp_word_in;
   count_type    polls_done_ff, polls_done_in;

   logic         supported;
   logic [15:0]  cmd;
   count_type    next_count;

   assign entry_pop = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // command toward the target
   always_comb begin
      supported = 1'b1;
      cmd       = CW_SHUTDOWN;
      unique case (cfg.target_state)
         ST_ENABLED: begin
            if (entry.state == ST_READY) cmd = CW_SWITCH_ON;
            else if (entry.state == ST_SWITCHED_ON || entry.state == ST_QUICK_STOP)
               cmd = CW_ENABLE_OP;
            else cmd = CW_SHUTDOWN;
         end
         ST_SWITCHED_ON:
            cmd = (entry.state == ST_SW_ON_DISABLED) ? CW_SHUTDOWN : CW_SWITCH_ON;
         ST_READY:          cmd = CW_SHUTDOWN;
         ST_SW_ON_DISABLED: cmd = CW_DISABLE_VOLTAGE;
         default:           supported = 1'b0;
      endcase
   end

   // saturating poll count
   assign next_count = (polls_done_ff != COUNT_MAX) ? count_type'(polls_done_ff + 1'b1)
                                                    : polls_done_ff;

   always_comb begin
      rsp_valid_in                = rsp_valid_ff;
      rsp_word_in                 = rsp_word_ff;
      polls_done_in               = polls_done_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (entry_pop) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.decoded_state = entry.state;
         rsp_word_in.command_valid = 1'b0;
         rsp_word_in.command_out   = 16'd0;
         polls_done_in             = '0;
         priority if (entry.err) begin
            rsp_word_in.outcome = OUT_ERROR;
         end else if (entry.state == state_type'(cfg.target_state)) begin
            rsp_word_in.outcome = OUT_REACHED;
         end else if (entry.state == ST_FAULT || entry.state == ST_FAULT_REACTION) begin
            rsp_word_in.outcome = OUT_FAULT;
         end else if (!supported) begin
            rsp_word_in.outcome = OUT_UNSUPPORTED;
         end else begin
            rsp_word_in.command_valid = 1'b1;
            rsp_word_in.command_out   = cmd;
            if (cmp_type'(next_count) >= cmp_type'(cfg.max_polls) ||
                next_count == COUNT_MAX) begin
               rsp_word_in.outcome = OUT_TIMEOUT;
            end else begin
               rsp_word_in.outcome = OUT_BUSY;
               polls_done_in       = next_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         polls_done_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         polls_done_ff <= polls_done_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// File: test/tb_drive_state_transition_sequencer_unit.sv
`timescale 1ns / 100ps

module tb_drive_state_transition_sequencer_unit;
   import dsts_pkg::*;

   // no-acceptance cycles before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // receiver hold-off, long enough to back the block up to its input
   localparam int LONG_HOLD = 120;
   // byte addresses: register index times four
   localparam logic [2:0] ADDR_TARGET    = {1'b0, REG_TARGET, 2'b00};
   localparam logic [2:0] ADDR_MAX_POLLS = {1'b0, REG_MAX_POLLS, 2'b00};

   typedef struct packed {
      logic [15:0] status;
      logic        failed;
   } poll_item_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // [15:0] status_reading
   logic [0:0]  req_tuser   = '0;   // [0] read_failed
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // [3:0] decoded_state, [4] command_valid,
                                    // [20:5] command_out, [23:21] outcome
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   drive_state_transition_sequencer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ------------------------------------------------------------------
   // Shadow of the block: register copies and the poll counter
   // ------------------------------------------------------------------
   logic [3:0]   target_mirror    = TARGET_RESET;
   logic [15:0]  max_polls_mirror = MAX_POLLS_RESET;
   count_type    polls_issued     = '0;

   poll_item_type pending_polls[$];   // words waiting for the driver
   rsp_word_type  expected_rsp[$];    // predicted results, oldest first
   int           mismatch_count = 0;
   bit           idle_on = 1'b1;     // random gaps/stalls enabled
   int           hold_ask = 0;       // bumped to request one long rsp hold-off

   // Status word -> drive state. Mask A picks out the four states that
   // ignore bit 5; everything else is resolved with mask B.
   function automatic state_type decode_status(input logic [15:0] status);
      case (status & MASK_A)
         PAT_NOTRDY: return ST_NOT_READY;
         PAT_SOD:    return ST_SW_ON_DISABLED;
         PAT_FREACT: return ST_FAULT_REACTION;
         PAT_FAULT:  return ST_FAULT;
         default: ;
      endcase
      case (status & MASK_B)
         PAT_READY:   return ST_READY;
         PAT_SWON:    return ST_SWITCHED_ON;
         PAT_ENABLED: return ST_ENABLED;
         PAT_QSTOP:   return ST_QUICK_STOP;
         default:     return ST_UNKNOWN;
      endcase
   endfunction

   // Next result for one poll; advances or clears the shadow counter.
   function automatic rsp_word_type sequence_poll(input logic [15:0] status,
                                                  input logic failed);
      rsp_word_type r;
      state_type    cur;
      logic [15:0]  cmd;
      count_type    next;
      r.decoded_state = ST_UNKNOWN;
      r.command_valid = 1'b0;
      r.command_out   = 16'h0000;
      r.outcome       = OUT_ERROR;
      // zero limit or failed read: word not looked at
      if (max_polls_mirror == 16'd0 || failed) begin
         polls_issued = '0;
         return r;
      end
      cur = decode_status(status);
      r.decoded_state = cur;
      if (cur == target_mirror) begin
         polls_issued = '0;
         r.outcome = OUT_REACHED;
         return r;
      end
      if (cur == ST_FAULT || cur == ST_FAULT_REACTION) begin
         polls_issued = '0;
         r.outcome = OUT_FAULT;
         return r;
      end
      case (target_mirror)
         ST_ENABLED: begin
            if (cur == ST_READY)
               cmd = CW_SWITCH_ON;
            else if (cur == ST_SWITCHED_ON || cur == ST_QUICK_STOP)
               cmd = CW_ENABLE_OP;
            else
               cmd = CW_SHUTDOWN;
         end
         ST_SWITCHED_ON: begin
            cmd = (cur == ST_SW_ON_DISABLED) ? CW_SHUTDOWN : CW_SWITCH_ON;
         end
         ST_READY:          cmd = CW_SHUTDOWN;
         ST_SW_ON_DISABLED: cmd = CW_DISABLE_VOLTAGE;
         default: begin
            // no transition path toward this target
            polls_issued = '0;
            r.outcome = OUT_UNSUPPORTED;
            return r;
         end
      endcase
      // counter saturates; hitting all-ones or the limit is a timeout
      next = polls_issued;
      if (next != COUNT_MAX)
         next = next + 1'b1;
      r.command_valid = 1'b1;
      r.command_out   = cmd;
      if (next >= max_polls_mirror || next == COUNT_MAX) begin
         polls_issued = '0;
         r.outcome = OUT_TIMEOUT;
      end else begin
         polls_issued = next;
         r.outcome = OUT_BUSY;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driver: feeds req from pending_polls, predicts on each accepted word
   // ------------------------------------------------------------------
   poll_item_type in_flight;
   int            send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp.push_back(sequence_poll(in_flight.status, in_flight.failed));
         // slot is free once the current word went through (or none offered)
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_polls.size() != 0) begin
               in_flight = pending_polls.pop_front();
               req_tdata  <= in_flight.status;
               req_tuser  <= in_flight.failed;
               req_tvalid <= 1'b1;
               if (idle_on && $urandom_range(0, 3) == 0)
                  send_gap = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor + receiver: checks each rsp word, drives rsp_tready
   // ------------------------------------------------------------------
   int hold_seen = 0;
   int hold_left = 0;
   int rsp_stall = 0;

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: rsp word %h with no poll pending", $realtime, rsp_tdata);
            end else begin
               want = expected_rsp.pop_front();
               if (got.decoded_state !== want.decoded_state ||
                   got.command_valid !== want.command_valid ||
                   got.command_out   !== want.command_out ||
                   got.outcome       !== want.outcome) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: state %0d/%0d valid %0b/%0b cmd %h/%h outcome %0d/%0d",
                              $realtime, want.decoded_state, got.decoded_state,
                              want.command_valid, got.command_valid,
                              want.command_out, got.command_out,
                              want.outcome, got.outcome);
               end
            end
         end
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no word moving on either side
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_poll(input logic [15:0] status, input logic failed);
      poll_item_type p;
      p.status = status;
      p.failed = failed;
      pending_polls.push_back(p);
   endtask

   // wait until every poll is sent and every result has come back
   task automatic settle();
      do
         @(negedge clock);
      while (pending_polls.size() != 0 || req_tvalid || expected_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // reprogram both registers with the block idle
   task automatic set_cfg(input logic [3:0] target, input logic [15:0] limit);
      settle();
      apb_write(ADDR_TARGET, {28'd0, target});
      target_mirror = target;
      apb_write(ADDR_MAX_POLLS, {16'd0, limit});
      max_polls_mirror = limit;
      @(negedge clock);
   endtask

   // A run of polls that mostly repeat one drive state with noise on the
   // don't-care bits, so the poll counter climbs; a few failed reads and
   // raw random words are mixed in.
   task automatic push_state_run(inout int n);
      logic [15:0] base;
      int          len;
      int          r;
      case ($urandom_range(0, 7))
         0:       base = PAT_NOTRDY;
         1:       base = PAT_SOD;
         2:       base = PAT_READY;
         3:       base = PAT_SWON;
         4:       base = PAT_ENABLED;
         5:       base = PAT_QSTOP;
         6:       base = PAT_FREACT;
         default: base = PAT_FAULT;
      endcase
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 6)
            push_poll(16'($urandom), 1'b1);
         else if (r < 16)
            push_poll(16'($urandom), 1'b0);
         else
            push_poll(base | (16'($urandom) & 16'hFF90), 1'b0);
      end
      n += len;
   endtask

   initial begin
      int          n;
      logic [3:0]  tgt;
      logic [15:0] lim;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // -- directed, reset config (target enabled, limit 100) --
      push_poll(16'h0000, 1'b0);   // not ready -> shutdown
      push_poll(16'h0040, 1'b0);   // switch-on disabled -> shutdown
      push_poll(16'h0021, 1'b0);   // ready -> switch on
      push_poll(16'h0023, 1'b0);   // switched on -> enable operation
      push_poll(16'h0007, 1'b0);   // quick stop -> enable operation
      push_poll(16'hFFB7, 1'b0);   // enabled with noise -> reached
      push_poll(16'h000F, 1'b0);   // fault reaction
      push_poll(16'h0008, 1'b0);   // fault
      push_poll(16'hFFFF, 1'b0);   // unknown -> shutdown
      push_poll(16'hFF90, 1'b0);   // not ready, all don't-care bits set
      push_poll(16'hFFFF, 1'b1);   // failed read, word ignored
      push_poll(16'h0000, 1'b0);   // counter restarted after the error

      set_cfg(ST_SW_ON_DISABLED, 16'd1);
      push_poll(16'h0000, 1'b0);   // disable voltage, limit of one -> timeout
      push_poll(16'h0040, 1'b0);   // reached
      set_cfg(ST_READY, 16'd2);
      push_poll(16'h0040, 1'b0);
      push_poll(16'h0040, 1'b0);   // second command -> timeout
      set_cfg(ST_SWITCHED_ON, 16'd3);
      push_poll(16'h0040, 1'b0);   // shutdown
      push_poll(16'h0027, 1'b0);   // switch on
      push_poll(16'h0023, 1'b0);   // reached
      set_cfg(ST_NOT_READY, 16'd100);
      push_poll(16'h0040, 1'b0);   // unsupported target
      push_poll(16'h0000, 1'b0);   // already there -> reached
      set_cfg(4'hF, 16'd100);
      push_poll(16'h0027, 1'b0);   // out-of-range target -> unsupported
      set_cfg(ST_UNKNOWN, 16'd100);
      push_poll(16'h0001, 1'b0);   // unknown equals target -> reached
      push_poll(16'h0008, 1'b0);
      set_cfg(ST_ENABLED, 16'd0);
      push_poll(16'h0027, 1'b0);   // zero limit -> error

      // -- long climb: counter runs into the limit, then restarts --
      set_cfg(ST_ENABLED, 16'd24);
      for (int i = 0; i < 30; i++)
         push_poll(16'($urandom) & ~MASK_A, 1'b0);
      push_poll(16'h0000, 1'b0);

      // -- random phases --
      for (int phase = 0; phase < 8; phase++) begin
         if ($urandom_range(0, 9) < 7)
            tgt = 4'($urandom_range(1, 4));
         else
            tgt = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 6))
            0:       lim = 16'd1;
            1:       lim = 16'd2;
            2:       lim = 16'($urandom_range(3, 8));
            3:       lim = 16'($urandom_range(9, 40));
            4:       lim = 16'hFFFF;
            5:       lim = 16'($urandom);
            default: lim = 16'd0;
         endcase
         if (phase == 7)
            idle_on = 1'b0;   // closing phase runs back to back
         set_cfg(tgt, lim);
         n = 0;
         while (n < 40) begin
            push_state_run(n);
            if (phase == 1 && n >= 25 && hold_ask == 0)
               hold_ask++;    // receiver holds off while the driver keeps offering
            if (phase == 3 && n >= 25 && n < 38)
               settle();      // sender pauses until every result is back
         end
      end

      settle();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
